### hdl/lbcc_pkg.sv
// ----------------------------------------------------------------------------
// lbcc_pkg - shared types and codes of the block cache tag controller
// Command and result codes, transfer structs, sequencer states and the
// control group broadcast to the recency cells.
// ----------------------------------------------------------------------------
package lbcc_pkg;

    // command codes
    localparam logic [1:0] CMD_READ       = 2'd0;
    localparam logic [1:0] CMD_WRITE      = 2'd1;
    localparam logic [1:0] CMD_READ_DONE  = 2'd2;
    localparam logic [1:0] CMD_WRITE_DONE = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_GRANT     = 3'd0;
    localparam logic [2:0] KIND_WRITEBACK = 3'd1;
    localparam logic [2:0] KIND_FETCH     = 3'd2;
    localparam logic [2:0] KIND_NOFREE    = 3'd3;
    localparam logic [2:0] KIND_BUSY      = 3'd4;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] position;
        logic [3:0]  entry_index;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  entry_slot;
        logic [31:0] block_number;
        logic        last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SEL,
        ST_WB,
        ST_FETCH,
        ST_FINAL
    } state_t;

    // update control broadcast to every cell
    typedef struct packed {
        logic mtf;      // move selected entry to the front, shifting the rest
        logic inplace;  // rewrite selected entry where it stands
    } cell_ctl_t;

endpackage

### hdl/lbcc_cell.sv
// ----------------------------------------------------------------------------
// lbcc_cell - one place of the recency chain
// Holds the entry at this recency place and its tag and lock state, matches
// it against the key and takes its neighbour's contents on a front move.
// ----------------------------------------------------------------------------
module lbcc_cell
    import lbcc_pkg::*;
#(
    parameter int PLACE = 0,
    parameter int ID_W  = 4,
    parameter int PW    = 4,
    parameter int BW    = 32,
    parameter int RD_W  = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  cell_ctl_t       ctl,
    input  logic [PW-1:0]   sel_place,
    input  logic [BW-1:0]   key_block,
    input  logic [3:0]      key_index,
    input  logic [ID_W-1:0] prev_id,
    input  logic [BW-1:0]   prev_block,
    input  logic            prev_valid,
    input  logic            prev_dirty,
    input  logic            prev_writer,
    input  logic [RD_W-1:0] prev_readers,
    input  logic [ID_W-1:0] new_id,
    input  logic [BW-1:0]   new_block,
    input  logic            new_valid,
    input  logic            new_dirty,
    input  logic            new_writer,
    input  logic [RD_W-1:0] new_readers,
    output logic [ID_W-1:0] id,
    output logic [BW-1:0]   block,
    output logic            valid,
    output logic            dirty,
    output logic            writer,
    output logic [RD_W-1:0] readers,
    output logic            hit,
    output logic            id_match,
    output logic            unlocked
);

    logic [ID_W-1:0] id_reg;
    logic [BW-1:0]   block_reg;
    logic            valid_reg;
    logic            dirty_reg;
    logic            writer_reg;
    logic [RD_W-1:0] readers_reg;
    logic            load;
    logic            take_new;

    // decide whether this place loads, and from where
    always_comb
    begin
        take_new = 1'b0;
        load     = 1'b0;
        if (ctl.mtf && (PW'(PLACE) <= sel_place))
        begin
            load     = 1'b1;
            take_new = (PLACE == 0);
        end
        else if (ctl.inplace && (PW'(PLACE) == sel_place))
        begin
            load     = 1'b1;
            take_new = 1'b1;
        end
    end

    // hold control state; reset to ascending order, all unlocked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg      <= ID_W'(PLACE);
            valid_reg   <= 1'b0;
            dirty_reg   <= 1'b0;
            writer_reg  <= 1'b0;
            readers_reg <= '0;
        end
        else if (load)
        begin
            id_reg      <= take_new ? new_id      : prev_id;
            valid_reg   <= take_new ? new_valid   : prev_valid;
            dirty_reg   <= take_new ? new_dirty   : prev_dirty;
            writer_reg  <= take_new ? new_writer  : prev_writer;
            readers_reg <= take_new ? new_readers : prev_readers;
        end
    end

    // hold block tag
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            block_reg <= take_new ? new_block : prev_block;
        end
    end

    assign id       = id_reg;
    assign block    = block_reg;
    assign valid    = valid_reg;
    assign dirty    = dirty_reg;
    assign writer   = writer_reg;
    assign readers  = readers_reg;
    assign hit      = valid_reg && (block_reg == key_block);
    assign id_match = (32'(id_reg) == 32'(key_index));
    assign unlocked = !writer_reg && (readers_reg == '0);

endmodule

### hdl/lru_block_cache_controller.sv
// ----------------------------------------------------------------------------
// lru_block_cache_controller - tag and lock controller of an LRU block cache
// Fully associative write-back tags kept in a chain of recency cells, with
// a small sequencer that looks up, selects and emits one to three results.
// ----------------------------------------------------------------------------
// Channel   Signals                 Transfer
// command   start, busy, request    start high while busy low
// result    strobe, result          strobe high, one cycle, cannot stall
//
// A command goes through a lookup step over the cells and a selection step,
// then gives its results back to back: write back and fetch where a miss
// needs them, then the final one. The next command is taken the cycle after the
// last result. Reset empties all entries and orders them by index, entry 0
// most recent. The receiver cannot stall, so no result is ever held back.
// ----------------------------------------------------------------------------
module lru_block_cache_controller
    import lbcc_pkg::*;
#(
    parameter int ENTRIES           = 16,
    parameter int BLOCK_NUMBER_BITS = 32,
    parameter int MAX_READERS       = 15
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic strobe,
    output rsp_t result
);

    localparam int ID_W = $clog2(ENTRIES);
    localparam int PW   = $clog2(ENTRIES);
    localparam int BW   = (BLOCK_NUMBER_BITS < 32) ? BLOCK_NUMBER_BITS : 32;
    localparam int RD_W = $clog2(MAX_READERS + 1);

    state_t state_reg, state_next;

    logic [1:0]    cmd_reg;
    logic [BW-1:0] blk_reg;
    logic [3:0]    idx_reg;

    logic [ENTRIES-1:0] hit_vec, idm_vec, unl_vec, vict_vec;
    logic [ENTRIES-1:0] hit_reg, idm_reg, vict_reg;

    logic [ID_W-1:0] c_id      [ENTRIES];
    logic [BW-1:0]   c_block   [ENTRIES];
    logic            c_valid   [ENTRIES];
    logic            c_dirty   [ENTRIES];
    logic            c_writer  [ENTRIES];
    logic [RD_W-1:0] c_readers [ENTRIES];

    logic [ENTRIES-1:0] sel_vec;
    logic            hit_any_c, found_c;
    logic [PW-1:0]   place_c;
    logic [ID_W-1:0] id_c;
    logic [BW-1:0]   block_c;
    logic            valid_c, dirty_c, writer_c;
    logic [RD_W-1:0] readers_c;

    logic            sel_hit_reg, sel_found_reg;
    logic [PW-1:0]   sel_place_reg;
    logic [ID_W-1:0] sel_id_reg;
    logic [BW-1:0]   sel_block_reg;
    logic            sel_valid_reg, sel_dirty_reg, sel_writer_reg;
    logic [RD_W-1:0] sel_readers_reg;

    logic            is_done, is_read, hit_busy, miss_c;
    cell_ctl_t       ctl;
    logic [BW-1:0]   new_block;
    logic            new_valid, new_dirty, new_writer;
    logic [RD_W-1:0] new_readers;

    // build the recency chain
    for (genvar p = 0; p < ENTRIES; p++)
    begin : g_cell
        logic [ID_W-1:0] pv_id;
        logic [BW-1:0]   pv_block;
        logic            pv_valid, pv_dirty, pv_writer;
        logic [RD_W-1:0] pv_readers;
        if (p == 0)
        begin : g_head
            assign pv_id      = sel_id_reg;
            assign pv_block   = new_block;
            assign pv_valid   = new_valid;
            assign pv_dirty   = new_dirty;
            assign pv_writer  = new_writer;
            assign pv_readers = new_readers;
        end
        else
        begin : g_link
            assign pv_id      = c_id[p-1];
            assign pv_block   = c_block[p-1];
            assign pv_valid   = c_valid[p-1];
            assign pv_dirty   = c_dirty[p-1];
            assign pv_writer  = c_writer[p-1];
            assign pv_readers = c_readers[p-1];
        end
        lbcc_cell #(
            .PLACE (p),
            .ID_W  (ID_W),
            .PW    (PW),
            .BW    (BW),
            .RD_W  (RD_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .sel_place    (sel_place_reg),
            .key_block    (blk_reg),
            .key_index    (idx_reg),
            .prev_id      (pv_id),
            .prev_block   (pv_block),
            .prev_valid   (pv_valid),
            .prev_dirty   (pv_dirty),
            .prev_writer  (pv_writer),
            .prev_readers (pv_readers),
            .new_id       (sel_id_reg),
            .new_block    (new_block),
            .new_valid    (new_valid),
            .new_dirty    (new_dirty),
            .new_writer   (new_writer),
            .new_readers  (new_readers),
            .id           (c_id[p]),
            .block        (c_block[p]),
            .valid        (c_valid[p]),
            .dirty        (c_dirty[p]),
            .writer       (c_writer[p]),
            .readers      (c_readers[p]),
            .hit          (hit_vec[p]),
            .id_match     (idm_vec[p]),
            .unlocked     (unl_vec[p])
        );
    end

    // pick the least recent unlocked place
    always_comb
    begin
        logic deeper;
        deeper   = 1'b0;
        vict_vec = '0;
        for (int p = ENTRIES - 1; p >= 0; p--)
        begin
            vict_vec[p] = unl_vec[p] && !deeper;
            deeper      = deeper || unl_vec[p];
        end
    end

    // select the place this command concerns and gather its contents
    always_comb
    begin
        hit_any_c = |hit_reg;
        if (cmd_reg[1])
            sel_vec = idm_reg;
        else if (hit_any_c)
            sel_vec = hit_reg;
        else
            sel_vec = vict_reg;
        found_c   = |sel_vec;
        place_c   = '0;
        id_c      = '0;
        block_c   = '0;
        valid_c   = 1'b0;
        dirty_c   = 1'b0;
        writer_c  = 1'b0;
        readers_c = '0;
        for (int p = 0; p < ENTRIES; p++)
        begin
            place_c   = place_c   | ({PW{sel_vec[p]}} & PW'(p));
            id_c      = id_c      | ({ID_W{sel_vec[p]}} & c_id[p]);
            block_c   = block_c   | ({BW{sel_vec[p]}} & c_block[p]);
            valid_c   = valid_c   | (sel_vec[p] & c_valid[p]);
            dirty_c   = dirty_c   | (sel_vec[p] & c_dirty[p]);
            writer_c  = writer_c  | (sel_vec[p] & c_writer[p]);
            readers_c = readers_c | ({RD_W{sel_vec[p]}} & c_readers[p]);
        end
    end

    // advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // capture command, lookup flags and selection
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= request.command;
            blk_reg <= request.position[BW-1:0];
            idx_reg <= request.entry_index;
        end
        if (state_reg == ST_LOOK)
        begin
            hit_reg  <= hit_vec;
            idm_reg  <= idm_vec;
            vict_reg <= vict_vec;
        end
        if (state_reg == ST_SEL)
        begin
            sel_hit_reg     <= hit_any_c;
            sel_found_reg   <= found_c;
            sel_place_reg   <= place_c;
            sel_id_reg      <= id_c;
            sel_block_reg   <= block_c;
            sel_valid_reg   <= valid_c;
            sel_dirty_reg   <= dirty_c;
            sel_writer_reg  <= writer_c;
            sel_readers_reg <= readers_c;
        end
    end

    // decode command and lock state
    always_comb
    begin
        is_done  = cmd_reg[1];
        is_read  = (cmd_reg == CMD_READ);
        miss_c   = !is_done && !hit_any_c && found_c;
        if (is_read)
            hit_busy = sel_writer_reg || (sel_readers_reg >= RD_W'(MAX_READERS));
        else
            hit_busy = sel_writer_reg || (sel_readers_reg != '0);
    end

    // work out the new contents of the selected entry
    always_comb
    begin
        new_block   = sel_block_reg;
        new_valid   = sel_valid_reg;
        new_dirty   = sel_dirty_reg;
        new_writer  = sel_writer_reg;
        new_readers = sel_readers_reg;
        if (cmd_reg == CMD_READ_DONE)
        begin
            if (sel_readers_reg != '0)
                new_readers = sel_readers_reg - RD_W'(1);
        end
        else if (cmd_reg == CMD_WRITE_DONE)
        begin
            new_writer = 1'b0;
        end
        else if (sel_hit_reg)
        begin
            if (is_read)
                new_readers = sel_readers_reg + RD_W'(1);
            else
            begin
                new_writer = 1'b1;
                new_dirty  = 1'b1;
            end
        end
        else
        begin
            new_block   = blk_reg;
            new_valid   = 1'b1;
            new_dirty   = !is_read;
            new_writer  = !is_read;
            new_readers = is_read ? RD_W'(1) : '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_LOOK;
            end
            ST_LOOK:
                state_next = ST_SEL;
            ST_SEL:
            begin
                if (miss_c && valid_c && dirty_c)
                    state_next = ST_WB;
                else if (miss_c && is_read)
                    state_next = ST_FETCH;
                else
                    state_next = ST_FINAL;
            end
            ST_WB:
                state_next = is_read ? ST_FETCH : ST_FINAL;
            ST_FETCH:
                state_next = ST_FINAL;
            ST_FINAL:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and cell updates
    always_comb
    begin
        busy                = (state_reg != ST_IDLE);
        strobe              = 1'b0;
        result.kind         = KIND_GRANT;
        result.entry_slot   = 4'(sel_id_reg);
        result.block_number = 32'(blk_reg);
        result.last         = 1'b0;
        ctl.mtf             = 1'b0;
        ctl.inplace         = 1'b0;
        unique case (state_reg)
            ST_WB:
            begin
                strobe              = 1'b1;
                result.kind         = KIND_WRITEBACK;
                result.block_number = 32'(sel_block_reg);
            end
            ST_FETCH:
            begin
                strobe      = 1'b1;
                result.kind = KIND_FETCH;
            end
            ST_FINAL:
            begin
                strobe      = 1'b1;
                result.last = 1'b1;
                if (is_done)
                begin
                    result.entry_slot   = idx_reg;
                    result.block_number = sel_valid_reg ? 32'(sel_block_reg) : 32'd0;
                    ctl.inplace         = sel_found_reg;
                end
                else if (sel_hit_reg && hit_busy)
                begin
                    result.kind = KIND_BUSY;
                end
                else if (!sel_found_reg)
                begin
                    result.kind       = KIND_NOFREE;
                    result.entry_slot = 4'd0;
                end
                else
                begin
                    ctl.mtf = 1'b1;
                end
            end
            default:
            begin
                strobe = 1'b0;
            end
        endcase
    end

endmodule

### hdl/lbcc_checker.sv
// ----------------------------------------------------------------------------
// lbcc_checker - port-level checks of the block cache tag controller
// Watches the command and result transfers and their sequencing in time.
// ----------------------------------------------------------------------------
module lbcc_checker
    import lbcc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic strobe,
    input rsp_t result
);

    // results only while a command is in hand
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result outside a command");

    // busy and no result in the cycle after a command is taken
    a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !strobe))
        else $error("command not held after transfer");

    // results of one command follow without a gap
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last) |=> strobe)
        else $error("gap inside a result burst");

    // ready again after the final result
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |=> !busy)
        else $error("busy after final result");

endmodule

bind lru_block_cache_controller lbcc_checker u_lbcc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench of the LRU block cache tag controller
// Commands come from a queue filled at time zero and go in through the
// start/busy handshake with random gaps. A software copy of the tag, lock
// and recency state predicts every result. A monitor checks each strobed
// result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import lbcc_pkg::*;

    localparam int ENTRY_COUNT = 16;
    localparam int READER_LIMIT = 15;
    localparam int IDLE_LIMIT = 600;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        req_t req;
        bit   drain;
    } pending_cmd_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    logic strobe;
    rsp_t result;

    pending_cmd_t pending_q[$];
    rsp_t         expected_q[$];
    int           errors;
    int           gap_left;
    bit           burst;
    bit           drain_wait;
    int           idle_cycles;

    // shadow copy of the cache tags
    logic [31:0] shadow_block[ENTRY_COUNT];
    bit          shadow_valid[ENTRY_COUNT];
    bit          shadow_dirty[ENTRY_COUNT];
    bit          shadow_writer[ENTRY_COUNT];
    int          shadow_readers[ENTRY_COUNT];
    int          shadow_order[ENTRY_COUNT];

    lru_block_cache_controller dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .strobe  (strobe),
        .result  (result)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic void push_result(input logic [2:0] kind, input int slot,
                                        input logic [31:0] blk, input bit last);
        rsp_t r;
        r.kind = kind;
        r.entry_slot = slot[3:0];
        r.block_number = blk;
        r.last = last;
        expected_q.push_back(r);
    endfunction

    function automatic void promote(input int e);
        int p;
        p = 0;
        while (p < ENTRY_COUNT && shadow_order[p] != e)
            p++;
        if (p >= ENTRY_COUNT)
            p = ENTRY_COUNT - 1;
        for (int i = p; i > 0; i--)
            shadow_order[i] = shadow_order[i - 1];
        shadow_order[0] = e;
    endfunction

    // work out the results of one accepted command and update the shadow
    function automatic void predict_command(input req_t rq);
        int          hit;
        int          victim;
        int          idx;
        logic [31:0] blk;
        hit = -1;
        victim = -1;
        idx = rq.entry_index;
        blk = rq.position;
        if (rq.command == CMD_READ_DONE || rq.command == CMD_WRITE_DONE)
        begin
            push_result(KIND_GRANT, idx, shadow_valid[idx] ? shadow_block[idx] : 32'd0, 1'b1);
            if (rq.command == CMD_READ_DONE)
            begin
                if (shadow_readers[idx] > 0)
                    shadow_readers[idx]--;
            end
            else
                shadow_writer[idx] = 1'b0;
            return;
        end
        for (int i = 0; i < ENTRY_COUNT; i++)
            if (hit < 0 && shadow_valid[i] && shadow_block[i] == blk)
                hit = i;
        if (hit >= 0)
        begin
            if (rq.command == CMD_READ)
            begin
                if (shadow_writer[hit] || shadow_readers[hit] >= READER_LIMIT)
                begin
                    push_result(KIND_BUSY, hit, blk, 1'b1);
                    return;
                end
                shadow_readers[hit]++;
            end
            else
            begin
                if (shadow_writer[hit] || shadow_readers[hit] > 0)
                begin
                    push_result(KIND_BUSY, hit, blk, 1'b1);
                    return;
                end
                shadow_writer[hit] = 1'b1;
                shadow_dirty[hit] = 1'b1;
            end
            promote(hit);
            push_result(KIND_GRANT, hit, blk, 1'b1);
            return;
        end
        // miss: least recent unlocked entry
        for (int p = ENTRY_COUNT - 1; p >= 0; p--)
            if (victim < 0 && !shadow_writer[shadow_order[p]]
                && shadow_readers[shadow_order[p]] == 0)
                victim = shadow_order[p];
        if (victim < 0)
        begin
            push_result(KIND_NOFREE, 0, blk, 1'b1);
            return;
        end
        if (shadow_valid[victim] && shadow_dirty[victim])
            push_result(KIND_WRITEBACK, victim, shadow_block[victim], 1'b0);
        shadow_dirty[victim] = 1'b0;
        shadow_block[victim] = blk;
        shadow_valid[victim] = 1'b1;
        if (rq.command == CMD_READ)
        begin
            push_result(KIND_FETCH, victim, blk, 1'b0);
            shadow_readers[victim] = 1;
        end
        else
        begin
            shadow_writer[victim] = 1'b1;
            shadow_dirty[victim] = 1'b1;
        end
        promote(victim);
        push_result(KIND_GRANT, victim, blk, 1'b1);
    endfunction

    function automatic void add_cmd(input logic [1:0] cmd, input logic [31:0] pos,
                                    input int idx, input bit drain);
        pending_cmd_t c;
        c.req.command = cmd;
        c.req.position = pos;
        c.req.entry_index = idx[3:0];
        c.drain = drain;
        pending_q.push_back(c);
    endfunction

    // driver: present the next command, hold it until the transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            request <= '0;
            gap_left <= 0;
            burst <= 1'b0;
            drain_wait <= 1'b0;
        end
        else if (start && busy)
        begin
            start <= 1'b1;
        end
        else
        begin
            if (start)
            begin
                predict_command(request);
                void'(pending_q.pop_front());
                if ($urandom_range(0, 15) == 0)
                    burst <= ~burst;
                gap_left <= burst ? 0 : $urandom_range(0, 13);
                start <= 1'b0;
                drain_wait <= pending_q.size() > 0 && pending_q[0].drain;
            end
            else if (drain_wait)
            begin
                if (expected_q.size() == 0)
                    drain_wait <= 1'b0;
            end
            else if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (pending_q.size() > 0)
            begin
                start <= 1'b1;
                request <= pending_q[0].req;
            end
        end
    end

    // monitor: check each strobed result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_q.size() == 0)
                report($sformatf("unexpected result %p", result));
            else
            begin
                if (result.kind !== expected_q[0].kind)
                    report($sformatf("kind %0d, want %0d", result.kind, expected_q[0].kind));
                if (result.entry_slot !== expected_q[0].entry_slot)
                    report($sformatf("entry_slot %0d, want %0d",
                                     result.entry_slot, expected_q[0].entry_slot));
                if (result.block_number !== expected_q[0].block_number)
                    report($sformatf("block_number %h, want %h",
                                     result.block_number, expected_q[0].block_number));
                if (result.last !== expected_q[0].last)
                    report($sformatf("last %b, want %b", result.last, expected_q[0].last));
                void'(expected_q.pop_front());
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("lru_block_cache_controller test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [31:0] pool[20];
        int          kind_pick;
        errors = 0;
        idle_cycles = 0;
        for (int i = 0; i < ENTRY_COUNT; i++)
        begin
            shadow_block[i] = '0;
            shadow_valid[i] = 1'b0;
            shadow_dirty[i] = 1'b0;
            shadow_writer[i] = 1'b0;
            shadow_readers[i] = 0;
            shadow_order[i] = i;
        end
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 20; i++)
            pool[i] = $urandom;

        // directed: lock every entry by write misses, then hit the locks
        add_cmd(CMD_READ_DONE, 32'd0, 3, 1'b0);
        add_cmd(CMD_WRITE_DONE, 32'd0, 15, 1'b0);
        for (int i = 0; i < ENTRY_COUNT; i++)
            add_cmd(CMD_WRITE, pool[i], 0, 1'b0);
        add_cmd(CMD_READ, pool[16], 0, 1'b0);
        add_cmd(CMD_READ, pool[1], 0, 1'b0);
        add_cmd(CMD_WRITE, pool[0], 0, 1'b0);
        add_cmd(CMD_WRITE_DONE, 32'd0, 0, 1'b0);
        add_cmd(CMD_WRITE_DONE, 32'd0, 1, 1'b0);
        add_cmd(CMD_READ, pool[17], 5, 1'b0);
        add_cmd(CMD_READ, pool[18], 5, 1'b0);

        // release every lock after the sender has drained
        for (int i = 0; i < ENTRY_COUNT; i++)
            add_cmd(CMD_WRITE_DONE, 32'd0, i, i == 0);
        for (int i = 0; i < ENTRY_COUNT; i++)
            add_cmd(CMD_READ_DONE, 32'd0, i, 1'b0);

        // saturate one entry with readers
        for (int i = 0; i < 17; i++)
            add_cmd(CMD_READ, pool[1], 0, 1'b0);

        // random traffic over a small block pool with some wide positions
        for (int n = 0; n < 160; n++)
        begin
            kind_pick = $urandom_range(0, 9);
            if (kind_pick < 4)
                add_cmd(CMD_READ, ($urandom_range(0, 7) == 0) ? $urandom
                        : pool[$urandom_range(0, 19)], $urandom_range(0, 15), n == 80);
            else if (kind_pick < 6)
                add_cmd(CMD_WRITE, ($urandom_range(0, 7) == 0) ? $urandom
                        : pool[$urandom_range(0, 19)], $urandom_range(0, 15), n == 80);
            else
                add_cmd(kind_pick < 8 ? CMD_READ_DONE : CMD_WRITE_DONE, $urandom,
                        $urandom_range(0, 15), n == 80);
        end

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_q.size() == 0 && expected_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("lru_block_cache_controller test passed");
        else
            $display("lru_block_cache_controller test failed");
        $finish;
    end

endmodule

### sim.f
hdl/lbcc_pkg.sv
hdl/lbcc_cell.sv
hdl/lru_block_cache_controller.sv
hdl/lbcc_checker.sv
sim/tb_top.sv
